// ----- rtl/core/shift_insert_byte_buffer_unit_assert.svh -----
// Assertion macros for the shift insert byte buffer.
`ifndef SHIFT_INSERT_BYTE_BUFFER_UNIT_ASSERT_SVH
`define SHIFT_INSERT_BYTE_BUFFER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SIBB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SIBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SIBB_ASSERT_IMPL(lbl, ante, cons, msg)
`define SIBB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/sibb_pkg.sv -----
// Shared types and constants of the shift insert byte buffer.
package sibb_pkg;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 10;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 11;

  localparam int MAX_DEPTH_DEF = 1024;
  localparam logic [CNT_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_PUT        = 3'd0;
  localparam logic [OP_W-1:0] OP_GET        = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  typedef struct packed {
    logic we;
    logic re;
    logic clr;
  } mreq_t;

endpackage

// ----- rtl/core/sibb_if.sv -----
// Request and result channel interfaces of the shift insert byte buffer.
interface sibb_req_if;
  logic                         valid;
  logic                         ready;
  logic [sibb_pkg::OP_W-1:0]    op;
  logic [sibb_pkg::IDX_W-1:0]   index;
  logic [sibb_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, op, index, data_byte, input ready);
  modport sink (input valid, op, index, data_byte, output ready);
endinterface

interface sibb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sibb_pkg::BYTE_W-1:0]  read_byte;
  logic                         status;
  logic [sibb_pkg::CNT_W-1:0]   fill_count;
  logic                         is_empty;
  logic                         is_full;

  modport source (output valid, read_byte, status, fill_count, is_empty, is_full,
                  input ready);
  modport sink (input valid, read_byte, status, fill_count, is_empty, is_full,
                output ready);
endinterface

// ----- rtl/core/shift_insert_byte_buffer_unit.sv -----
// Top level of the shift insert byte buffer.
// The block keeps up to MAX_DEPTH bytes in one memory and a count of occupied slots.
// Requests arrive on in_req (op, index, data_byte) and each gives one result on out_rsp
// (read_byte, status, fill_count, is_empty, is_full); both use valid and ready.
// cfg_we with cfg_wdata sets buffer_size, the capacity in use; write it while idle.
// One request is worked on at a time. Get, push_back, clear, failed requests,
// push_front on an empty buffer, erase of the last slot and a put at or below the
// high-water mark go from acceptance straight to the finish state, which loads the
// result register. A push_front over n bytes and an erase that moves m bytes first
// pass through the shift state: the memory has one write port, so a shift moves one
// byte per cycle. A put that lands g slots above the high-water mark first zeroes
// those slots in the fill state. Clear writes no slots, since slots at or above the
// mark read as zero. The next request is accepted in the cycle after the result is
// loaded, even while the result still waits for out_rsp.ready; a stalled receiver
// holds the block only when a second result is ready.
// Synchronous reset empties the buffer, sets buffer_size to 1024 (MAX_DEPTH if that is
// smaller) and needs no clearing pass.
`include "shift_insert_byte_buffer_unit_assert.svh"

module shift_insert_byte_buffer_unit #(
  parameter int MAX_DEPTH = sibb_pkg::MAX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sibb_pkg::CNT_W-1:0]  cfg_wdata,
  sibb_req_if.sink                    in_req,
  sibb_rsp_if.source                  out_rsp
);

  localparam int AW = $clog2(MAX_DEPTH);
  localparam int CW = $clog2(MAX_DEPTH + 1);

  sibb_pkg::mreq_t              mreq;
  logic [AW-1:0]                mem_waddr;
  logic [sibb_pkg::BYTE_W-1:0]  mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [sibb_pkg::BYTE_W-1:0]  mem_rdata;
  logic [CW-1:0]                mem_hw;

  sibb_ctrl #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .mreq      (mreq),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_hw    (mem_hw)
  );

  sibb_store #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .mreq      (mreq),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_hw    (mem_hw)
  );

  `SIBB_ASSERT_NEXT(a_one_at_a_time, in_req.valid && in_req.ready, !in_req.ready, "request accepted while busy")
  `SIBB_ASSERT_IMPL(a_no_rw_same_slot, mreq.we && mreq.re, mem_waddr != mem_raddr, "read and write hit one slot")
  `SIBB_ASSERT_IMPL(a_byte_only_ok, out_rsp.valid && (out_rsp.read_byte != '0), !out_rsp.status, "byte on failed request")
  `SIBB_ASSERT_IMPL(a_empty_count, out_rsp.valid && out_rsp.is_empty, out_rsp.fill_count == '0, "empty with nonzero count")

endmodule

// ----- rtl/core/sibb_store.sv -----
// Byte memory with a high-water mark, so that clear does not have to write every slot.
module sibb_store #(
  parameter int MAX_DEPTH = sibb_pkg::MAX_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sibb_pkg::mreq_t                   mreq,
  input  logic [$clog2(MAX_DEPTH)-1:0]      mem_waddr,
  input  logic [sibb_pkg::BYTE_W-1:0]       mem_wdata,
  input  logic [$clog2(MAX_DEPTH)-1:0]      mem_raddr,
  output logic [sibb_pkg::BYTE_W-1:0]       mem_rdata,
  output logic [$clog2(MAX_DEPTH + 1)-1:0]  mem_hw
);

  localparam int CW = $clog2(MAX_DEPTH + 1);

  // Every slot at or above the mark reads as zero.
  logic [sibb_pkg::BYTE_W-1:0] mem [MAX_DEPTH];
  logic [sibb_pkg::BYTE_W-1:0] rdata_r;
  logic                        zero_r;
  logic [CW-1:0]               hw_r;
  logic [CW-1:0]               hw_nxt;
  logic [CW-1:0]               hw_cand;

  always_comb begin
    hw_cand = CW'(mem_waddr) + CW'(1);
    hw_nxt  = hw_r;
    priority if (mreq.clr) begin
      hw_nxt = '0;
    end else if (mreq.we && (hw_cand > hw_r)) begin
      hw_nxt = hw_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
    end else begin
      hw_r <= hw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rdata_r <= mem[mem_raddr];
      zero_r  <= (CW'(mem_raddr) >= hw_r);
    end
  end

  assign mem_rdata = zero_r ? '0 : rdata_r;
  assign mem_hw    = hw_r;

endmodule

// ----- rtl/core/sibb_ctrl.sv -----
// Request sequencer: decodes operations, walks shifts and zero fills and holds the result register.
module sibb_ctrl #(
  parameter int MAX_DEPTH = sibb_pkg::MAX_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sibb_pkg::CNT_W-1:0]        cfg_wdata,
  sibb_req_if.sink                          in_req,
  sibb_rsp_if.source                        out_rsp,
  output sibb_pkg::mreq_t                   mreq,
  output logic [$clog2(MAX_DEPTH)-1:0]      mem_waddr,
  output logic [sibb_pkg::BYTE_W-1:0]       mem_wdata,
  output logic [$clog2(MAX_DEPTH)-1:0]      mem_raddr,
  input  logic [sibb_pkg::BYTE_W-1:0]       mem_rdata,
  input  logic [$clog2(MAX_DEPTH + 1)-1:0]  mem_hw
);

  localparam int AW = $clog2(MAX_DEPTH);
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int XW = (CW > sibb_pkg::CNT_W) ? CW : sibb_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [sibb_pkg::CNT_W-1:0]   cfg_r, cfg_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         err_r, err_nxt;
  logic                         get_r, get_nxt;
  logic                         front_r, front_nxt;
  logic                         up_r, up_nxt;
  logic [sibb_pkg::BYTE_W-1:0]  data_r, data_nxt;
  logic [AW-1:0]                rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]                waddr_r, waddr_nxt;
  logic [CW-1:0]                left_r, left_nxt;
  logic                         wpend_r, wpend_nxt;
  logic                         ovalid_r, ovalid_nxt;
  logic [sibb_pkg::BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic                         ostat_r, ostat_nxt;
  logic [sibb_pkg::CNT_W-1:0]   ocnt_r, ocnt_nxt;
  logic                         oempty_r, oempty_nxt;
  logic                         ofull_r, ofull_nxt;

  logic [XW-1:0] cfg_x;
  logic [XW-1:0] size_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] idx_x;

  always_comb begin
    cfg_x = XW'(cfg_r);
    cnt_x = XW'(cnt_r);
    idx_x = XW'(in_req.index);
    priority if (cfg_x == '0) begin
      size_x = XW'(1);
    end else if (cfg_x > XW'(MAX_DEPTH)) begin
      size_x = XW'(MAX_DEPTH);
    end else begin
      size_x = cfg_x;
    end
  end

  assign in_req.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cfg_nxt     = cfg_r;
    cnt_nxt     = cnt_r;
    err_nxt     = err_r;
    get_nxt     = get_r;
    front_nxt   = front_r;
    up_nxt      = up_r;
    data_nxt    = data_r;
    rd_addr_nxt = rd_addr_r;
    waddr_nxt   = waddr_r;
    left_nxt    = left_r;
    wpend_nxt   = wpend_r;
    ovalid_nxt  = ovalid_r;
    obyte_nxt   = obyte_r;
    ostat_nxt   = ostat_r;
    ocnt_nxt    = ocnt_r;
    oempty_nxt  = oempty_r;
    ofull_nxt   = ofull_r;
    mreq        = '0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;

    if (cfg_we) begin
      cfg_nxt = cfg_wdata;
    end
    if (out_rsp.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          err_nxt   = 1'b0;
          get_nxt   = 1'b0;
          front_nxt = 1'b0;
          data_nxt  = in_req.data_byte;
          state_nxt = ST_FIN;
          unique case (in_req.op)
            sibb_pkg::OP_PUT: begin
              if (idx_x < size_x) begin
                if (idx_x > XW'(mem_hw)) begin
                  rd_addr_nxt = AW'(in_req.index);
                  state_nxt   = ST_FILL;
                end else begin
                  mreq.we   = 1'b1;
                  mem_waddr = AW'(in_req.index);
                  mem_wdata = in_req.data_byte;
                end
                if (idx_x >= cnt_x) begin
                  cnt_nxt = CW'(idx_x + XW'(1));
                end
              end else begin
                err_nxt = 1'b1;
              end
            end
            sibb_pkg::OP_GET: begin
              if (idx_x < cnt_x) begin
                mreq.re   = 1'b1;
                mem_raddr = AW'(in_req.index);
                get_nxt   = 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
            end
            sibb_pkg::OP_PUSH_FRONT: begin
              if (cnt_x < size_x) begin
                cnt_nxt = cnt_r + CW'(1);
                if (cnt_r == '0) begin
                  mreq.we   = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = in_req.data_byte;
                end else begin
                  front_nxt   = 1'b1;
                  up_nxt      = 1'b1;
                  rd_addr_nxt = AW'(cnt_x - XW'(1));
                  left_nxt    = cnt_r;
                  wpend_nxt   = 1'b0;
                  state_nxt   = ST_SHIFT;
                end
              end else begin
                err_nxt = 1'b1;
              end
            end
            sibb_pkg::OP_PUSH_BACK: begin
              if (cnt_x < size_x) begin
                mreq.we   = 1'b1;
                mem_waddr = AW'(cnt_r);
                mem_wdata = in_req.data_byte;
                cnt_nxt   = cnt_r + CW'(1);
              end else begin
                err_nxt = 1'b1;
              end
            end
            sibb_pkg::OP_ERASE: begin
              if (idx_x < cnt_x) begin
                cnt_nxt = cnt_r - CW'(1);
                if ((idx_x + XW'(1)) < cnt_x) begin
                  up_nxt      = 1'b0;
                  rd_addr_nxt = AW'(idx_x + XW'(1));
                  left_nxt    = CW'(cnt_x - idx_x - XW'(1));
                  wpend_nxt   = 1'b0;
                  state_nxt   = ST_SHIFT;
                end
              end else begin
                err_nxt = 1'b1;
              end
            end
            sibb_pkg::OP_CLEAR: begin
              mreq.clr = 1'b1;
              cnt_nxt  = '0;
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        // Slots between the mark and the put index are zeroed one per cycle.
        mreq.we = 1'b1;
        if (mem_hw == CW'(rd_addr_r)) begin
          mem_waddr = rd_addr_r;
          mem_wdata = data_r;
          state_nxt = ST_FIN;
        end else begin
          mem_waddr = AW'(mem_hw);
        end
      end
      ST_SHIFT: begin
        // Reads run one slot ahead of the writes, so a cycle never reads the slot it writes.
        if (wpend_r) begin
          mreq.we   = 1'b1;
          mem_waddr = waddr_r;
          mem_wdata = mem_rdata;
        end
        if (left_r != '0) begin
          mreq.re     = 1'b1;
          mem_raddr   = rd_addr_r;
          wpend_nxt   = 1'b1;
          waddr_nxt   = up_r ? (rd_addr_r + AW'(1)) : (rd_addr_r - AW'(1));
          rd_addr_nxt = up_r ? (rd_addr_r - AW'(1)) : (rd_addr_r + AW'(1));
          left_nxt    = left_r - CW'(1);
        end else begin
          wpend_nxt = 1'b0;
          if (!wpend_r) begin
            if (front_r) begin
              mreq.we   = 1'b1;
              mem_waddr = '0;
              mem_wdata = data_r;
            end
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!ovalid_r || out_rsp.ready) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = get_r ? mem_rdata : '0;
          ostat_nxt  = err_r;
          ocnt_nxt   = sibb_pkg::CNT_W'(cnt_r);
          oempty_nxt = (cnt_r == '0);
          ofull_nxt  = (cnt_x >= size_x);
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cfg_r    <= sibb_pkg::CFG_RESET;
      cnt_r    <= '0;
      wpend_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cfg_r    <= cfg_nxt;
      cnt_r    <= cnt_nxt;
      wpend_r  <= wpend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r     <= err_nxt;
    get_r     <= get_nxt;
    front_r   <= front_nxt;
    up_r      <= up_nxt;
    data_r    <= data_nxt;
    rd_addr_r <= rd_addr_nxt;
    waddr_r   <= waddr_nxt;
    left_r    <= left_nxt;
    obyte_r   <= obyte_nxt;
    ostat_r   <= ostat_nxt;
    ocnt_r    <= ocnt_nxt;
    oempty_r  <= oempty_nxt;
    ofull_r   <= ofull_nxt;
  end

  assign out_rsp.valid      = ovalid_r;
  assign out_rsp.read_byte  = obyte_r;
  assign out_rsp.status     = ostat_r;
  assign out_rsp.fill_count = ocnt_r;
  assign out_rsp.is_empty   = oempty_r;
  assign out_rsp.is_full    = ofull_r;

endmodule
